// ===== hw/rtl/lrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lrfp_pkg
// Shared types and constants for the raw frame packer.
// ----------------------------------------------------------------------------
package lrfp_pkg;

    localparam int ADDR_W              = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [15:0] PKT_LEN_RESET = 16'd352;

    // register index, taken from paddr[2]
    localparam logic REG_PKT_LEN = 1'b0;

    localparam logic [7:0] TAG_BYTE   = 8'h20;  // stereo element, instance 0
    localparam logic [7:0] FLAGS_BYTE = 8'h12;  // partial-frame and escape flags
    localparam logic [7:0] END_BYTE   = 8'hC0;  // rest of end tag plus padding

    // one frame, classified by the front end
    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [6:0]         carry;
        logic               first;
        logic               last;
        logic [15:0]        size;
    } frame_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/lrfp_ifs.sv =====
// ----------------------------------------------------------------------------
// lrfp_ifs
// Valid/ready channels: stereo frames in, packet bytes out.
// ----------------------------------------------------------------------------
interface lrfp_frame_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       packet_end;

    modport source (output valid, output packet_byte, output packet_end, input ready);
    modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface

// ===== hw/rtl/lrfp_front.sv =====
// ----------------------------------------------------------------------------
// lrfp_front
// Accepts frames, tracks packet position and carry, pushes frame commands.
// ----------------------------------------------------------------------------
module lrfp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          pkt_len,
    input  lrfp_pkg::q_status_t  q_status,
    lrfp_frame_if.sink           frame_in,
    output logic                 push,
    output lrfp_pkg::frame_cmd_t cmd
);

    logic [15:0] frame_idx_reg;
    logic [15:0] frame_idx_next;
    logic [6:0]  carry_reg;
    logic [6:0]  carry_next;
    logic        is_last;

    assign frame_in.ready = !q_status.full;
    assign push           = frame_in.valid && frame_in.ready;

    // close once index + 1 reaches or passes the size (size 0 acts as 1)
    assign is_last = ({1'b0, frame_idx_reg} + 17'd1) >= {1'b0, pkt_len};

    always_comb
    begin
        cmd.left  = frame_in.left_sample;
        cmd.right = frame_in.right_sample;
        cmd.carry = carry_reg;
        cmd.first = (frame_idx_reg == 16'd0);
        cmd.last  = is_last;
        cmd.size  = pkt_len;

        frame_idx_next = frame_idx_reg;
        carry_next     = carry_reg;
        if (push)
        begin
            if (is_last)
            begin
                frame_idx_next = 16'd0;
                carry_next     = 7'd0;
            end
            else
            begin
                frame_idx_next = frame_idx_reg + 16'd1;
                carry_next     = frame_in.right_sample[6:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_idx_reg <= 16'd0;
            carry_reg     <= 7'd0;
        end
        else
        begin
            frame_idx_reg <= frame_idx_next;
            carry_reg     <= carry_next;
        end
    end

endmodule

// ===== hw/rtl/lrfp_queue.sv =====
// ----------------------------------------------------------------------------
// lrfp_queue
// Small FIFO of frame commands between front and back end.
// ----------------------------------------------------------------------------
module lrfp_queue #(
    parameter int DEPTH = lrfp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lrfp_pkg::frame_cmd_t push_cmd,
    input  logic                 pop,
    output lrfp_pkg::frame_cmd_t head_cmd,
    output lrfp_pkg::q_status_t  status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lrfp_pkg::frame_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/lrfp_back.sv =====
// ----------------------------------------------------------------------------
// lrfp_back
// Serializes one frame command into packet bytes, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
module lrfp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrfp_pkg::frame_cmd_t head_cmd,
    input  lrfp_pkg::q_status_t  q_status,
    output logic                 pop,
    lrfp_byte_if.source          byte_out
);

    typedef enum logic [3:0] {
        STEP_TAG,
        STEP_ZERO,
        STEP_FLAGS,
        STEP_SZ3,
        STEP_SZ2,
        STEP_SZ1,
        STEP_JOIN,   // size low bits or carry, plus left msb
        STEP_LHI,
        STEP_LLO,
        STEP_RHI,
        STEP_RLO,
        STEP_TAIL
    } step_t;

    step_t      step_reg;
    step_t      cur_step;
    step_t      end_step;
    logic       in_prog_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_end_reg;
    logic       head_valid;
    logic       advance;
    logic [7:0] cur_byte;

    assign head_valid = !q_status.empty;
    assign advance    = head_valid && (!out_valid_reg || byte_out.ready);
    assign cur_step   = in_prog_reg ? step_reg : (head_cmd.first ? STEP_TAG : STEP_JOIN);
    assign end_step   = head_cmd.last ? STEP_TAIL : STEP_RHI;
    assign pop        = advance && (cur_step == end_step);

    always_comb
    begin
        unique case (cur_step)
            STEP_TAG:   cur_byte = lrfp_pkg::TAG_BYTE;
            STEP_ZERO:  cur_byte = 8'h00;
            STEP_FLAGS: cur_byte = lrfp_pkg::FLAGS_BYTE;
            STEP_SZ3:   cur_byte = 8'h00;
            STEP_SZ2:   cur_byte = {7'd0, head_cmd.size[15]};
            STEP_SZ1:   cur_byte = head_cmd.size[14:7];
            STEP_JOIN:  cur_byte = head_cmd.first ? {head_cmd.size[6:0], head_cmd.left[15]}
                                                  : {head_cmd.carry, head_cmd.left[15]};
            STEP_LHI:   cur_byte = head_cmd.left[14:7];
            STEP_LLO:   cur_byte = {head_cmd.left[6:0], head_cmd.right[15]};
            STEP_RHI:   cur_byte = head_cmd.right[14:7];
            STEP_RLO:   cur_byte = {head_cmd.right[6:0], 1'b1};   // end-tag start bit
            STEP_TAIL:  cur_byte = lrfp_pkg::END_BYTE;
            default:    cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_TAG;
            in_prog_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= cur_byte;
                out_end_reg   <= (cur_step == STEP_TAIL);
                if (cur_step == end_step)
                begin
                    in_prog_reg <= 1'b0;
                end
                else
                begin
                    in_prog_reg <= 1'b1;
                    step_reg    <= step_t'(cur_step + 4'd1);
                end
            end
            else if (byte_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign byte_out.valid       = out_valid_reg;
    assign byte_out.packet_byte = out_byte_reg;
    assign byte_out.packet_end  = out_end_reg;

    a_end_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_end_reg) |-> (out_byte_reg == lrfp_pkg::END_BYTE))
        else $error("packet end flag on a byte other than the end byte");

    a_pop_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cur_step == STEP_RHI || cur_step == STEP_TAIL))
        else $error("frame retired before its last byte");

    a_prog_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_prog_reg |-> head_valid)
        else $error("frame in progress with an empty queue");

endmodule

// ===== hw/rtl/lossless_raw_frame_packer.sv =====
// ----------------------------------------------------------------------------
// lossless_raw_frame_packer
// Packs 16-bit stereo frames into uncompressed lossless-audio packets.
// ----------------------------------------------------------------------------
// Path: an accepted frame is written into the queue, then its first byte is
//   captured in the back-end byte output register.
// Throughput: one byte per cycle while a frame is queued and output not stalled:
//   4 bytes per mid-packet frame, 10 for a first, 6 for a last, 12 for both.
// Reset: packet length returns to 352, frame index and carry clear, queue empty.
// ----------------------------------------------------------------------------
module lossless_raw_frame_packer #(
    parameter int QUEUE_DEPTH = lrfp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB-style configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lrfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // channels
    lrfp_frame_if.sink                  frame_in,
    lrfp_byte_if.source                 byte_out
);

    logic [15:0]          pkt_len_reg;
    logic                 cfg_write;
    logic                 push;
    logic                 pop;
    lrfp_pkg::frame_cmd_t push_cmd;
    lrfp_pkg::frame_cmd_t head_cmd;
    lrfp_pkg::q_status_t  q_status;

    // Register file: one register, decoded on the word address bit.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == lrfp_pkg::REG_PKT_LEN) ? {16'd0, pkt_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_len_reg <= lrfp_pkg::PKT_LEN_RESET;
        end
        else if (cfg_write && (paddr[2] == lrfp_pkg::REG_PKT_LEN))
        begin
            pkt_len_reg <= pwdata[15:0];
        end
    end

    // Front end: decides first/last frame and the carried bits per frame,
    // so the back end only has to walk a byte schedule.
    lrfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pkt_len    (pkt_len_reg),
        .q_status   (q_status),
        .frame_in   (frame_in),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Decoupling queue: the front keeps taking frames while bytes drain.
    lrfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back end: header, sample bytes with one-bit offset, and packet tail.
    lrfp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .byte_out (byte_out)
    );

endmodule
